// ===== design/psch_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Preemptive priority scheduler package
// Shared constants, field widths, codes and types of the scheduler block.
// ---------------------------------------------------------------------------
package psch_pkg;

  localparam int unsigned MAX_TASKS_DEF = 16;
  localparam int unsigned TIME_BITS_DEF = 16;

  // Width of one digit handled per cycle by the serial comparators.
  localparam int unsigned DIG_BITS = 4;

  localparam int unsigned COUNT_W   = 5;
  localparam int unsigned SLOT_W    = 4;
  localparam int unsigned BURST_W   = 16;
  localparam int unsigned ARRIVAL_W = 16;
  localparam int unsigned PRIO_W    = 8;
  localparam int unsigned TIME_W    = 16;
  localparam int unsigned WAIT_W    = 16;

  typedef logic [DIG_BITS-1:0] digit_t;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_TICK = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_WAIT_RD,
    ST_WAIT_WR,
    ST_PICK_RD,
    ST_PICK_WR,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic clear;
    logic step;
  } ser_ctl_t;

endpackage

// ===== design/psch_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Preemptive priority scheduler channels
// Valid/ready channels for input items and for result items.
// ---------------------------------------------------------------------------
interface psch_in_if;
  logic                          valid;
  logic                          ready;
  psch_pkg::op_e                 operation;
  logic [psch_pkg::SLOT_W-1:0]    slot;
  logic [psch_pkg::BURST_W-1:0]   burst_length;
  logic [psch_pkg::ARRIVAL_W-1:0] arrival_time;
  logic [psch_pkg::PRIO_W-1:0]    priority_level;

  modport source (
    output valid, operation, slot, burst_length, arrival_time, priority_level,
    input  ready
  );
  modport sink (
    input  valid, operation, slot, burst_length, arrival_time, priority_level,
    output ready
  );
endinterface

interface psch_out_if;
  logic                        valid;
  logic                        ready;
  logic [psch_pkg::TIME_W-1:0] time_now;
  logic [psch_pkg::SLOT_W-1:0] running_slot;
  logic                        idle;
  logic                        switched;
  logic                        finished;
  logic [psch_pkg::TIME_W-1:0] turnaround;
  logic [psch_pkg::WAIT_W-1:0] waiting_total;

  modport source (
    output valid, time_now, running_slot, idle, switched, finished, turnaround,
           waiting_total,
    input  ready
  );
  modport sink (
    input  valid, time_now, running_slot, idle, switched, finished, turnaround,
           waiting_total,
    output ready
  );
endinterface

// ===== design/psch_ser_cmp.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Serial less-than comparator
// Compares two operands one digit per cycle while step is set, least significant digit first.
// ---------------------------------------------------------------------------
module psch_ser_cmp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  psch_pkg::ser_ctl_t ctl_i,
  input  psch_pkg::digit_t   a_i,
  input  psch_pkg::digit_t   b_i,
  output logic               lt_o
);
  import psch_pkg::*;

  logic lt_q;
  logic lt_d;

  // A higher digit decides; an equal digit keeps the verdict of the lower ones.
  assign lt_o = (a_i < b_i) || ((a_i == b_i) && lt_q);

  always_comb begin
    lt_d = lt_q;
    if (ctl_i.clear) begin
      lt_d = 1'b0;
    end else if (ctl_i.step) begin
      lt_d = lt_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lt_q <= 1'b0;
    end else begin
      lt_q <= lt_d;
    end
  end

endmodule

// ===== design/preemptive_priority_scheduler.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Preemptive priority scheduler
// Task table with a digit-serial scan that picks, runs and accounts one tick.
// ---------------------------------------------------------------------------
// A load item writes the table and produces no result. A tick item is accepted,
// scans each of the n slots with a read and then one compare per digit, then, when
// a task is ready, updates the waiting count of every other ready slot and the
// executed count of the picked one, and posts the result once the output is free.
// Reset clears time, the last running slot, the task count and all control;
// table entries are valid only after a load.
module preemptive_priority_scheduler #(
  parameter int unsigned MAX_TASKS = psch_pkg::MAX_TASKS_DEF,
  parameter int unsigned TIME_BITS = psch_pkg::TIME_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [psch_pkg::COUNT_W-1:0] cfg_wdata_i,
  psch_in_if.sink                      in_i,
  psch_out_if.source                   out_o
);
  import psch_pkg::*;

  localparam int unsigned IDX_W     = $clog2(MAX_TASKS);
  localparam int unsigned CNT_W     = $clog2(MAX_TASKS + 1);
  localparam int unsigned CMP_BITS  = (TIME_BITS > BURST_W) ? TIME_BITS : BURST_W;
  localparam int unsigned NDIG      = (CMP_BITS + DIG_BITS - 1) / DIG_BITS;
  localparam int unsigned SER_W     = NDIG * DIG_BITS;
  localparam int unsigned DIG_CNT_W = (NDIG > 1) ? $clog2(NDIG) : 1;

  // Task table.
  logic [BURST_W-1:0]   burst_mem   [MAX_TASKS];
  logic [ARRIVAL_W-1:0] arrival_mem [MAX_TASKS];
  logic [PRIO_W-1:0]    prio_mem    [MAX_TASKS];
  logic [BURST_W-1:0]   exe_mem     [MAX_TASKS];
  logic [WAIT_W-1:0]    wait_mem    [MAX_TASKS];

  state_e                 state_q, state_d;
  logic [COUNT_W-1:0]     task_count_q;
  logic [CNT_W-1:0]       scan_n;
  logic [CNT_W-1:0]       idx_q;
  logic [IDX_W-1:0]       idx;
  logic [DIG_CNT_W-1:0]   dig_q;
  logic                   found_q;
  logic [IDX_W-1:0]       pick_q;
  logic [MAX_TASKS-1:0]   ready_q;
  logic                   last_valid_q;
  logic [IDX_W-1:0]       last_slot_q;
  logic [TIME_BITS-1:0]   time_q;
  logic                   fin_q;
  logic                   out_valid_q;

  logic [PRIO_W-1:0]      best_q;
  logic [TIME_W-1:0]      turn_q;
  logic [WAIT_W-1:0]      waitv_q;

  // Read registers; the scan operands rotate through them a digit at a time.
  logic [SER_W-1:0]       arr_sr_q, bur_sr_q, exe_sr_q, pri_sr_q, time_sr_q, best_sr_q;
  logic [PRIO_W-1:0]      pri_hold_q;
  logic [WAIT_W-1:0]      wait_rd_q;

  logic [TIME_W-1:0]      res_time_q, res_turn_q;
  logic [SLOT_W-1:0]      res_slot_q;
  logic                   res_idle_q, res_sw_q, res_fin_q;
  logic [WAIT_W-1:0]      res_wait_q;

  logic                   in_fire, tick_fire, slot_ok, out_free;
  logic                   last_dig, last_idx;
  logic                   not_arrived, exe_lt_bur, pri_lt_best;
  logic                   ready_now, take;
  logic [IDX_W-1:0]       ld_idx;
  logic                   rd_en, rot_en;
  logic [IDX_W-1:0]       rd_idx, wr_idx;
  logic                   load_we, exe_we, wait_we;
  logic [BURST_W-1:0]     exe_wdata, exe_inc;
  logic [WAIT_W-1:0]      wait_wdata, wait_inc;
  logic [TIME_BITS-1:0]   time_inc, turn_full;
  ser_ctl_t               ser_ctl;

  assign in_fire   = in_i.valid && in_i.ready;
  assign tick_fire = in_fire && (in_i.operation == OP_TICK);
  assign slot_ok   = 32'(in_i.slot) < MAX_TASKS;
  assign ld_idx    = IDX_W'(in_i.slot);
  assign out_free  = !out_valid_q || out_o.ready;
  assign idx       = idx_q[IDX_W-1:0];
  assign last_dig  = dig_q == DIG_CNT_W'(NDIG - 1);
  assign last_idx  = CNT_W'(idx_q + 1'b1) == scan_n;

  always_comb begin
    if (32'(task_count_q) >= MAX_TASKS) begin
      scan_n = CNT_W'(MAX_TASKS);
    end else begin
      scan_n = CNT_W'(task_count_q);
    end
  end

  // Serial compares: time < arrival, executed < burst, priority < best.
  psch_ser_cmp u_arr_cmp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ser_ctl),
    .a_i    (time_sr_q[DIG_BITS-1:0]),
    .b_i    (arr_sr_q[DIG_BITS-1:0]),
    .lt_o   (not_arrived)
  );

  psch_ser_cmp u_exe_cmp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ser_ctl),
    .a_i    (exe_sr_q[DIG_BITS-1:0]),
    .b_i    (bur_sr_q[DIG_BITS-1:0]),
    .lt_o   (exe_lt_bur)
  );

  psch_ser_cmp u_pri_cmp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ser_ctl),
    .a_i    (pri_sr_q[DIG_BITS-1:0]),
    .b_i    (best_sr_q[DIG_BITS-1:0]),
    .lt_o   (pri_lt_best)
  );

  assign ready_now = !not_arrived && exe_lt_bur;
  assign take      = ready_now && (!found_q || pri_lt_best);

  assign exe_inc   = exe_sr_q[BURST_W-1:0] + 1'b1;
  assign wait_inc  = (wait_rd_q == '1) ? wait_rd_q : wait_rd_q + 1'b1;
  assign time_inc  = time_q + 1'b1;
  assign turn_full = time_inc - TIME_BITS'(arr_sr_q);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (tick_fire) begin
          state_d = (scan_n == '0) ? ST_DONE : ST_SCAN_RD;
        end
      end
      ST_SCAN_RD: begin
        state_d = ST_SCAN_CMP;
      end
      ST_SCAN_CMP: begin
        if (last_dig) begin
          if (!last_idx) begin
            state_d = ST_SCAN_RD;
          end else if (found_q || take) begin
            state_d = ST_WAIT_RD;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_WAIT_RD: begin
        state_d = ST_WAIT_WR;
      end
      ST_WAIT_WR: begin
        state_d = last_idx ? ST_PICK_RD : ST_WAIT_RD;
      end
      ST_PICK_RD: begin
        state_d = ST_PICK_WR;
      end
      ST_PICK_WR: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    rd_en      = 1'b0;
    rot_en     = 1'b0;
    rd_idx     = idx;
    wr_idx     = idx;
    load_we    = 1'b0;
    exe_we     = 1'b0;
    wait_we    = 1'b0;
    exe_wdata  = '0;
    wait_wdata = '0;
    ser_ctl    = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire && (in_i.operation == OP_LOAD) && slot_ok) begin
          load_we = 1'b1;
          exe_we  = 1'b1;
          wait_we = 1'b1;
          wr_idx  = ld_idx;
        end
      end
      ST_SCAN_RD: begin
        rd_en         = 1'b1;
        ser_ctl.clear = 1'b1;
      end
      ST_SCAN_CMP: begin
        rot_en       = 1'b1;
        ser_ctl.step = 1'b1;
      end
      ST_WAIT_RD: begin
        rd_en = 1'b1;
      end
      ST_WAIT_WR: begin
        wait_we    = ready_q[idx] && (idx != pick_q);
        wait_wdata = wait_inc;
      end
      ST_PICK_RD: begin
        rd_en  = 1'b1;
        rd_idx = pick_q;
      end
      ST_PICK_WR: begin
        exe_we    = 1'b1;
        wr_idx    = pick_q;
        exe_wdata = exe_inc;
      end
      ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // Table writes.
  always_ff @(posedge clk_i) begin
    if (load_we) begin
      burst_mem[wr_idx]   <= in_i.burst_length;
      arrival_mem[wr_idx] <= in_i.arrival_time;
      prio_mem[wr_idx]    <= in_i.priority_level;
    end
    if (exe_we) begin
      exe_mem[wr_idx] <= exe_wdata;
    end
    if (wait_we) begin
      wait_mem[wr_idx] <= wait_wdata;
    end
  end

  // Table reads into the serial registers, which rotate back in place.
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      arr_sr_q   <= SER_W'(arrival_mem[rd_idx]);
      bur_sr_q   <= SER_W'(burst_mem[rd_idx]);
      exe_sr_q   <= SER_W'(exe_mem[rd_idx]);
      pri_sr_q   <= SER_W'(prio_mem[rd_idx]);
      pri_hold_q <= prio_mem[rd_idx];
      wait_rd_q  <= wait_mem[rd_idx];
      time_sr_q  <= SER_W'(time_q);
      best_sr_q  <= SER_W'(best_q);
    end else if (rot_en) begin
      arr_sr_q  <= {arr_sr_q[DIG_BITS-1:0], arr_sr_q[SER_W-1:DIG_BITS]};
      bur_sr_q  <= {bur_sr_q[DIG_BITS-1:0], bur_sr_q[SER_W-1:DIG_BITS]};
      exe_sr_q  <= {exe_sr_q[DIG_BITS-1:0], exe_sr_q[SER_W-1:DIG_BITS]};
      pri_sr_q  <= {pri_sr_q[DIG_BITS-1:0], pri_sr_q[SER_W-1:DIG_BITS]};
      time_sr_q <= {time_sr_q[DIG_BITS-1:0], time_sr_q[SER_W-1:DIG_BITS]};
      best_sr_q <= {best_sr_q[DIG_BITS-1:0], best_sr_q[SER_W-1:DIG_BITS]};
    end
  end

  // Sequencer and scheduling state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      task_count_q <= '0;
      idx_q        <= '0;
      dig_q        <= '0;
      found_q      <= 1'b0;
      pick_q       <= '0;
      ready_q      <= '0;
      last_valid_q <= 1'b0;
      last_slot_q  <= '0;
      time_q       <= '0;
      fin_q        <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        task_count_q <= cfg_wdata_i;
      end
      // In the result stage the post below decides the valid flag alone.
      if (out_o.valid && out_o.ready && (state_q != ST_DONE)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (tick_fire) begin
            idx_q   <= '0;
            found_q <= 1'b0;
            fin_q   <= 1'b0;
          end
        end
        ST_SCAN_RD: begin
          dig_q <= '0;
        end
        ST_SCAN_CMP: begin
          dig_q <= dig_q + 1'b1;
          if (last_dig) begin
            ready_q[idx] <= ready_now;
            if (take) begin
              found_q <= 1'b1;
              pick_q  <= idx;
            end
            idx_q <= last_idx ? '0 : CNT_W'(idx_q + 1'b1);
          end
        end
        ST_WAIT_WR: begin
          idx_q <= last_idx ? '0 : CNT_W'(idx_q + 1'b1);
        end
        ST_PICK_WR: begin
          fin_q <= exe_inc == bur_sr_q[BURST_W-1:0];
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            last_valid_q <= found_q;
            last_slot_q  <= pick_q;
            time_q       <= time_inc;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if ((state_q == ST_SCAN_CMP) && last_dig && take) begin
      best_q <= pri_hold_q;
    end
    if (state_q == ST_PICK_WR) begin
      turn_q  <= TIME_W'(turn_full);
      waitv_q <= wait_rd_q;
    end
    if ((state_q == ST_DONE) && out_free) begin
      res_time_q <= TIME_W'(time_q);
      res_slot_q <= found_q ? SLOT_W'(pick_q) : '0;
      res_idle_q <= !found_q;
      res_sw_q   <= found_q ? (!last_valid_q || (last_slot_q != pick_q)) : last_valid_q;
      res_fin_q  <= fin_q;
      res_turn_q <= fin_q ? turn_q : '0;
      res_wait_q <= fin_q ? waitv_q : '0;
    end
  end

  assign in_i.ready          = state_q == ST_IDLE;
  assign out_o.valid         = out_valid_q;
  assign out_o.time_now      = res_time_q;
  assign out_o.running_slot  = res_slot_q;
  assign out_o.idle          = res_idle_q;
  assign out_o.switched      = res_sw_q;
  assign out_o.finished      = res_fin_q;
  assign out_o.turnaround    = res_turn_q;
  assign out_o.waiting_total = res_wait_q;

`ifndef SYNTHESIS
  // A task that is posted as running was found ready within the scanned slots.
  a_pick_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE) && found_q |-> ready_q[pick_q] && (CNT_W'(pick_q) < scan_n))
    else $error("picked slot is not a ready scanned slot");

  // A new result is only posted when leaving the result stage.
  a_post_from_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_DONE)
    else $error("result posted outside the result stage");

  // Time advances by exactly one per posted tick.
  a_time_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE) && out_free |=> time_q == TIME_BITS'($past(time_q) + 1'b1))
    else $error("time did not advance by one tick");

  // The scan index never leaves the scanned range.
  a_scan_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN_CMP) || (state_q == ST_WAIT_WR) |-> idx_q < scan_n)
    else $error("scan index beyond task count");
`endif

endmodule

// ===== dv/psch_schedule_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Scheduler schedule checker
// Watches the item and result channels, keeps its own copy of the task
// table, predicts every tick report and compares each accepted report.
// ---------------------------------------------------------------------------
module psch_schedule_checker
  import psch_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [COUNT_W-1:0] cfg_wdata_i,
  psch_in_if                 in_mon,
  psch_out_if                out_mon,
  output int unsigned        mismatch_count_o,
  output int unsigned        reports_due_o
);

  localparam int unsigned SLOTS = MAX_TASKS_DEF;
  localparam logic [COUNT_W-1:0] NO_SLOT = '1;

  typedef struct packed {
    logic [TIME_W-1:0] time_now;
    logic [SLOT_W-1:0] running_slot;
    logic              idle;
    logic              switched;
    logic              finished;
    logic [TIME_W-1:0] turnaround;
    logic [WAIT_W-1:0] waiting_total;
  } tick_report_t;

  logic [BURST_W-1:0]   burst_q   [SLOTS];
  logic [ARRIVAL_W-1:0] arrival_q [SLOTS];
  logic [PRIO_W-1:0]    prio_q    [SLOTS];
  logic [BURST_W-1:0]   run_q     [SLOTS];
  logic [WAIT_W-1:0]    wait_q    [SLOTS];
  logic [TIME_W-1:0]    now_t;
  logic [COUNT_W-1:0]   last_slot;
  logic [COUNT_W-1:0]   task_count;
  tick_report_t         due_reports [$];
  int unsigned          mismatches;

  function automatic bit slot_is_ready(int unsigned s);
    return (arrival_q[s] <= now_t) && (run_q[s] < burst_q[s]);
  endfunction

  // One scheduler tick: pick, run, account and advance time.
  function automatic tick_report_t schedule_tick();
    tick_report_t r;
    int unsigned  scan;
    int unsigned  pick;
    bit           found;
    r     = '0;
    scan  = (task_count > SLOTS) ? SLOTS : int'(task_count);
    pick  = 0;
    found = 1'b0;
    for (int unsigned s = 0; s < scan; s++) begin
      if (slot_is_ready(s) && (!found || prio_q[s] < prio_q[pick])) begin
        pick  = s;
        found = 1'b1;
      end
    end
    r.time_now = now_t;
    r.idle     = !found;
    if (found) begin
      for (int unsigned s = 0; s < scan; s++) begin
        if (s != pick && slot_is_ready(s) && wait_q[s] != '1) begin
          wait_q[s]++;
        end
      end
      run_q[pick]++;
      if (run_q[pick] == burst_q[pick]) begin
        r.finished      = 1'b1;
        r.turnaround    = now_t + 16'd1 - arrival_q[pick];
        r.waiting_total = wait_q[pick];
      end
      r.switched     = (last_slot != COUNT_W'(pick));
      r.running_slot = SLOT_W'(pick);
      last_slot      = COUNT_W'(pick);
    end else begin
      // An idle tick forgets the last task, so the next one counts as a switch.
      r.switched = (last_slot != NO_SLOT);
      last_slot  = NO_SLOT;
    end
    now_t++;
    return r;
  endfunction

  task automatic check_field(string name, logic [15:0] want_v, logic [15:0] got_v);
    if (want_v !== got_v) begin
      mismatches++;
      $display("%0t: %s expected %0d, actual %0d", $time, name, want_v, got_v);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    tick_report_t seen;
    tick_report_t want;
    if (!rst_ni) begin
      for (int unsigned s = 0; s < SLOTS; s++) begin
        burst_q[s]   = '0;
        arrival_q[s] = '0;
        prio_q[s]    = '0;
        run_q[s]     = '0;
        wait_q[s]    = '0;
      end
      now_t      = '0;
      last_slot  = NO_SLOT;
      task_count = '0;
      due_reports.delete();
      mismatches = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        seen = '{out_mon.time_now, out_mon.running_slot, out_mon.idle, out_mon.switched,
                 out_mon.finished, out_mon.turnaround, out_mon.waiting_total};
        if (due_reports.size() == 0) begin
          mismatches++;
          $display("%0t: tick report expected none, actual %h", $time, seen);
        end else begin
          want = due_reports.pop_front();
          check_field("time_now", want.time_now, seen.time_now);
          check_field("running_slot", 16'(want.running_slot), 16'(seen.running_slot));
          check_field("idle", 16'(want.idle), 16'(seen.idle));
          check_field("switched", 16'(want.switched), 16'(seen.switched));
          check_field("finished", 16'(want.finished), 16'(seen.finished));
          check_field("turnaround", want.turnaround, seen.turnaround);
          check_field("waiting_total", want.waiting_total, seen.waiting_total);
        end
      end
      if (cfg_we_i) begin
        task_count = cfg_wdata_i;
      end
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.operation == OP_LOAD) begin
          burst_q[in_mon.slot]   = in_mon.burst_length;
          arrival_q[in_mon.slot] = in_mon.arrival_time;
          prio_q[in_mon.slot]    = in_mon.priority_level;
          run_q[in_mon.slot]     = '0;
          wait_q[in_mon.slot]    = '0;
        end else begin
          due_reports.push_back(schedule_tick());
        end
      end
    end
    mismatch_count_o <= mismatches;
    reports_due_o    <= due_reports.size();
  end

endmodule

// ===== dv/preemptive_priority_scheduler_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Preemptive priority scheduler testbench
// Drives task loads and ticks with random gaps and result stalls, changes
// the task count between phases and lets the schedule checker judge.
// ---------------------------------------------------------------------------
module preemptive_priority_scheduler_tb;
  import psch_pkg::*;

  localparam int unsigned RANDOM_ITEMS   = 1750;
  localparam int unsigned QUIET_CYCLES   = 130;
  localparam int unsigned DRAIN_CYCLES   = 150;
  localparam int unsigned WATCHDOG_LIMIT = 2000;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [COUNT_W-1:0] cfg_wdata_i;
  int unsigned        mismatch_count;
  int unsigned        reports_due;
  logic [TIME_W-1:0]  clock_tick;
  bit                 jitter_on;
  int unsigned        quiet_cycles;

  psch_in_if  in_ch ();
  psch_out_if out_ch ();

  preemptive_priority_scheduler dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  psch_schedule_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_mon           (in_ch),
    .out_mon          (out_ch),
    .mismatch_count_o (mismatch_count),
    .reports_due_o    (reports_due)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic send_item(op_e op, logic [SLOT_W-1:0] slot, logic [BURST_W-1:0] burst,
                           logic [ARRIVAL_W-1:0] arrival, logic [PRIO_W-1:0] prio);
    int unsigned gap;
    gap = (jitter_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid          <= 1'b1;
    in_ch.operation      <= op;
    in_ch.slot           <= slot;
    in_ch.burst_length   <= burst;
    in_ch.arrival_time   <= arrival;
    in_ch.priority_level <= prio;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    if (op == OP_TICK) begin
      clock_tick++;
    end
  endtask

  task automatic tick();
    send_item(OP_TICK, '0, '0, '0, '0);
  endtask

  // Mostly short tasks arriving around the present tick, with close priorities.
  task automatic load_fresh_task(logic [SLOT_W-1:0] slot);
    logic [BURST_W-1:0]   burst;
    logic [ARRIVAL_W-1:0] arrival;
    logic [PRIO_W-1:0]    prio;
    int unsigned          r;
    r = $urandom_range(0, 19);
    if (r < 14)      burst = BURST_W'($urandom_range(1, 6));
    else if (r < 17) burst = BURST_W'($urandom_range(7, 40));
    else if (r < 19) burst = BURST_W'($urandom_range(1, 65535));
    else             burst = '0;
    r = $urandom_range(0, 19);
    if (r < 14)      arrival = clock_tick - 16'd3 + ARRIVAL_W'($urandom_range(0, 9));
    else if (r < 18) arrival = clock_tick + ARRIVAL_W'($urandom_range(10, 40));
    else             arrival = ARRIVAL_W'($urandom_range(0, 65535));
    r = $urandom_range(0, 19);
    if (r < 10)      prio = PRIO_W'($urandom_range(0, 3));
    else if (r < 16) prio = PRIO_W'($urandom_range(0, 255));
    else if (r < 18) prio = '0;
    else             prio = '1;
    send_item(OP_LOAD, slot, burst, arrival, prio);
  endtask

  // The count only changes once the block has gone quiet.
  task automatic write_task_count(logic [COUNT_W-1:0] value);
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (reports_due != 0) @(posedge clk_i);
    repeat (QUIET_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    int unsigned stall_left;
    stall_left   = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (jitter_on && stall_left == 0 && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 4);
      end
      if (stall_left != 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we_i) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("preemptive_priority_scheduler test failed");
    $finish;
  end

  initial begin
    int unsigned          random_items;
    int unsigned          phase;
    int unsigned          active;
    int unsigned          phase_len;
    logic [COUNT_W-1:0]   count_v;
    logic [SLOT_W-1:0]    slot;
    rst_ni               <= 1'b0;
    cfg_we_i             <= 1'b0;
    cfg_wdata_i          <= '0;
    in_ch.valid          <= 1'b0;
    in_ch.operation      <= OP_LOAD;
    in_ch.slot           <= '0;
    in_ch.burst_length   <= '0;
    in_ch.arrival_time   <= '0;
    in_ch.priority_level <= '0;
    clock_tick = '0;
    jitter_on  = 1'b1;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty table: the tick is idle and reports no switch.
    tick();
    send_item(OP_LOAD, 4'd0, 16'd2, 16'd0, 8'd8);
    send_item(OP_LOAD, 4'd1, 16'd1, 16'd2, 8'd8);
    // A zero burst never becomes ready.
    send_item(OP_LOAD, 4'd2, 16'd0, 16'd0, 8'd0);
    send_item(OP_LOAD, 4'd3, 16'd3, 16'd1, 8'd3);
    send_item(OP_LOAD, 4'd4, 16'hFFFF, 16'hFFFF, 8'd0);
    for (int s = 5; s < 16; s++) begin
      send_item(OP_LOAD, SLOT_W'(s), 16'd1, ARRIVAL_W'(s), 8'hFF);
    end
    // Preemption by slot 3, a priority tie won by slot 0, then an idle tick.
    write_task_count(5'd4);
    repeat (7) tick();
    // A count above the table size scans the whole table.
    write_task_count(5'd31);
    repeat (4) tick();

    random_items = 0;
    phase        = 0;
    while (random_items < RANDOM_ITEMS) begin
      case (phase)
        0:       count_v = 5'd16;
        1:       count_v = 5'd1;
        2:       count_v = 5'd31;
        3:       count_v = 5'd0;
        default: begin
          case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11: count_v = COUNT_W'($urandom_range(1, 5));
            12, 13, 14, 15, 16:                  count_v = COUNT_W'($urandom_range(6, 16));
            default:                             count_v = COUNT_W'($urandom_range(0, 31));
          endcase
        end
      endcase
      jitter_on = (random_items < RANDOM_ITEMS * 85 / 100) && ($urandom_range(0, 4) != 0);
      write_task_count(count_v);
      active = (count_v > 16) ? 16 : int'(count_v);
      for (int unsigned s = 0; s < active; s++) begin
        load_fresh_task(SLOT_W'(s));
        random_items++;
      end
      phase_len = $urandom_range(20, 60);
      repeat (phase_len) begin
        if ($urandom_range(0, 3) == 0) begin
          if (active != 0 && $urandom_range(0, 5) != 0) begin
            slot = SLOT_W'($urandom_range(0, active - 1));
          end else begin
            slot = SLOT_W'($urandom_range(0, 15));
          end
          load_fresh_task(slot);
        end else begin
          tick();
        end
        random_items++;
      end
      phase++;
    end

    jitter_on = 1'b0;
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (reports_due != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && reports_due == 0) begin
      $display("preemptive_priority_scheduler test passed");
    end else begin
      $display("preemptive_priority_scheduler test failed");
    end
    $finish;
  end

endmodule
